[src/tty_line_edit_fifo_assert.svh]
// Assertion macros for the terminal line edit buffer.
// Used by the port checker; needs clk and arst_n in the including scope.
`ifndef TTY_LINE_EDIT_FIFO_ASSERT_SVH
`define TTY_LINE_EDIT_FIFO_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define TLE_ASSERT_NOW(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("%m: check failed");

// Checks that a condition holds in the cycle after its trigger.
`define TLE_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("%m: check failed");

`endif

[src/tle_pkg.sv]
// Types and constants shared by the terminal line edit buffer.
// No dependencies.
`timescale 1ns / 1ps

package tle_pkg;

	localparam logic       OP_KEY        = 1'b0;
	localparam logic       OP_READ       = 1'b1;
	localparam logic [7:0] KEY_BACKSPACE = 8'h08;
	localparam logic [7:0] KEY_RETURN    = 8'h0D;
	localparam int         FILL_W        = 4;

	typedef struct packed {
		logic       operation;
		logic [7:0] key_char;
	} item_t;

	typedef struct packed {
		logic              echo_valid;
		logic [7:0]        echo_char;
		logic              key_stored;
		logic              key_dropped;
		logic              line_complete;
		logic              read_valid;
		logic [7:0]        read_char;
		logic              read_line_end;
		logic [FILL_W-1:0] fill_level;
	} result_t;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} ring_wr_t;

endpackage

[src/tle_ring.sv]
// Key byte ring storage with one write port and two registered read ports.
// Depends on tle_pkg for the write request type.
`timescale 1ns / 1ps

module tle_ring #(
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  tle_pkg::ring_wr_t wr,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [7:0]        rd_data_a,
	output logic [7:0]        rd_data_b
);
	import tle_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
	end

	// A read that lands on the entry written at the same edge returns the new byte.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= (wr.en && wr_addr == rd_addr_a) ? wr.data : mem_q[rd_addr_a];
			rd_data_b <= (wr.en && wr_addr == rd_addr_b) ? wr.data : mem_q[rd_addr_b];
		end
	end

endmodule

[src/tle_edit.sv]
// Line edit decision logic: applies one key or read word to the counters.
// Depends on tle_pkg for word types and key codes.
`timescale 1ns / 1ps

module tle_edit #(
	parameter int ADDR_W = 3
) (
	input  tle_pkg::item_t    item,
	input  logic [7:0]        newest,
	input  logic [7:0]        oldest,
	input  logic [ADDR_W:0]   wr_cnt,
	input  logic [ADDR_W:0]   rd_cnt,
	output logic [ADDR_W:0]   wr_cnt_next,
	output logic [ADDR_W:0]   rd_cnt_next,
	output tle_pkg::ring_wr_t wr,
	output tle_pkg::result_t  result
);
	import tle_pkg::*;

	localparam int CNT_W = ADDR_W + 1;

	logic [CNT_W-1:0] level;
	logic [CNT_W-1:0] level_next;

	assign level      = wr_cnt - rd_cnt;
	assign level_next = wr_cnt_next - rd_cnt_next;

	always_comb begin
		wr_cnt_next = wr_cnt;
		rd_cnt_next = rd_cnt;
		wr.en       = 1'b0;
		wr.data     = item.key_char;
		result      = '0;
		case (item.operation)
			OP_KEY: begin
				if (item.key_char == KEY_BACKSPACE) begin
					if (level != '0 && newest != KEY_RETURN) begin
						wr_cnt_next       = wr_cnt - CNT_W'(1);
						result.echo_valid = 1'b1;
						result.echo_char  = item.key_char;
					end
				end else if (level[ADDR_W]) begin
					result.key_dropped = 1'b1;
				end else begin
					wr.en                = 1'b1;
					wr_cnt_next          = wr_cnt + CNT_W'(1);
					result.key_stored    = 1'b1;
					result.echo_valid    = 1'b1;
					result.echo_char     = item.key_char;
					result.line_complete = (item.key_char == KEY_RETURN);
				end
			end
			OP_READ: begin
				if (level != '0) begin
					rd_cnt_next          = rd_cnt + CNT_W'(1);
					result.read_valid    = 1'b1;
					result.read_char     = oldest;
					result.read_line_end = (oldest == KEY_RETURN);
				end
			end
			default: begin
				result = '0;
			end
		endcase
		result.fill_level = FILL_W'(level_next);
	end

endmodule

[src/tty_line_edit_fifo.sv]
// Top level of the terminal line edit buffer.
// Depends on tle_pkg, tle_ring and tle_edit.
`timescale 1ns / 1ps

// Takes one key or read word per cycle while item_stall is low and returns one
// result word per word taken: the word waits in the input register, where the ring
// bytes at the newest and oldest positions have already been read, and then moves
// into the result register. A stall on the result side holds the input
// register and then stalls the input side. The ring holds 2**RING_DEPTH_LOG2
// bytes; fill_level shows the low four bits of the count.
module tty_line_edit_fifo #(
	parameter int RING_DEPTH_LOG2 = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tle_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output tle_pkg::result_t result
);
	import tle_pkg::*;

	localparam int ADDR_W = RING_DEPTH_LOG2;
	localparam int CNT_W  = ADDR_W + 1;

	logic             valid_s1;
	item_t            item_s1;
	logic [CNT_W-1:0] wr_cnt_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] wr_cnt_next;
	logic [CNT_W-1:0] rd_cnt_next;
	logic [CNT_W-1:0] wr_cnt_sel;
	logic [CNT_W-1:0] rd_cnt_sel;
	logic [CNT_W-1:0] newest_cnt;
	logic [7:0]       newest;
	logic [7:0]       oldest;
	ring_wr_t         wr_req;
	ring_wr_t         wr;
	result_t          result_d;
	logic             advance;
	logic             accept;

	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign wr.en      = wr_req.en && advance;
	assign wr.data    = wr_req.data;
	assign wr_cnt_sel = advance ? wr_cnt_next : wr_cnt_q;
	assign rd_cnt_sel = advance ? rd_cnt_next : rd_cnt_q;
	assign newest_cnt = wr_cnt_sel - CNT_W'(1);

	tle_ring #(
		.ADDR_W(ADDR_W)
	) u_ring (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_cnt_q[ADDR_W-1:0]),
		.rd_en    (accept),
		.rd_addr_a(newest_cnt[ADDR_W-1:0]),
		.rd_addr_b(rd_cnt_sel[ADDR_W-1:0]),
		.rd_data_a(newest),
		.rd_data_b(oldest)
	);

	tle_edit #(
		.ADDR_W(ADDR_W)
	) u_edit (
		.item       (item_s1),
		.newest     (newest),
		.oldest     (oldest),
		.wr_cnt     (wr_cnt_q),
		.rd_cnt     (rd_cnt_q),
		.wr_cnt_next(wr_cnt_next),
		.rd_cnt_next(rd_cnt_next),
		.wr         (wr_req),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
			wr_cnt_q     <= '0;
			rd_cnt_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid <= 1'b1;
				wr_cnt_q     <= wr_cnt_next;
				rd_cnt_q     <= rd_cnt_next;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (advance) begin
			result <= result_d;
		end
	end

endmodule

[src/tle_checker.sv]
// Port checker for the terminal line edit buffer, bound to the top level.
// Depends on tle_pkg and tty_line_edit_fifo_assert.svh.
`timescale 1ns / 1ps
`include "tty_line_edit_fifo_assert.svh"

module tle_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input tle_pkg::result_t result
);
	import tle_pkg::*;

	`TLE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	`TLE_ASSERT_NOW(a_stored_echoes, result_valid && result.key_stored,
		result.echo_valid && !result.key_dropped && !result.read_valid)
	`TLE_ASSERT_NOW(a_empty_read_quiet, result_valid && !result.read_valid,
		result.read_char == 8'h00 && !result.read_line_end)
	`TLE_ASSERT_NOW(a_line_is_return, result_valid && result.line_complete,
		result.echo_valid && result.echo_char == KEY_RETURN && result.key_stored)

endmodule

bind tty_line_edit_fifo tle_checker u_tle_checker (.*);

[bench/tty_line_edit_fifo_test.sv]
// Self-checking testbench for the terminal line edit buffer: directed and random
// key, backspace and read words, each result compared with a ring shadow.
// Depends on tle_pkg and tty_line_edit_fifo.
`timescale 1ns / 1ps

module tty_line_edit_fifo_test;
	import tle_pkg::*;

	localparam int DEPTH_LOG2 = 3;
	localparam int DEPTH = 1 << DEPTH_LOG2;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WORDS = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	logic [7:0] shadow_ring [DEPTH];
	logic [DEPTH_LOG2:0] shadow_wr = '0;
	logic [DEPTH_LOG2:0] shadow_rd = '0;
	result_t tty_results_due [$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	tty_line_edit_fifo #(.RING_DEPTH_LOG2(DEPTH_LOG2)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Applies one word to the shadow ring and returns the result it should produce.
	function automatic result_t edit_line_buffer(item_t w);
		result_t r;
		logic [DEPTH_LOG2:0] level;
		logic [DEPTH_LOG2:0] newest;
		r = '0;
		level = shadow_wr - shadow_rd;
		if (w.operation == OP_KEY) begin
			if (w.key_char == KEY_BACKSPACE) begin
				newest = shadow_wr - 1'b1;
				if (level != 0) begin
					if (shadow_ring[newest[DEPTH_LOG2-1:0]] != KEY_RETURN) begin
						shadow_wr = newest;
						r.echo_valid = 1'b1;
						r.echo_char = w.key_char;
					end
				end
			end else if (level >= DEPTH) begin
				r.key_dropped = 1'b1;
			end else begin
				shadow_ring[shadow_wr[DEPTH_LOG2-1:0]] = w.key_char;
				shadow_wr = shadow_wr + 1'b1;
				r.key_stored = 1'b1;
				r.echo_valid = 1'b1;
				r.echo_char = w.key_char;
				r.line_complete = (w.key_char == KEY_RETURN);
			end
		end else if (level != 0) begin
			r.read_char = shadow_ring[shadow_rd[DEPTH_LOG2-1:0]];
			shadow_rd = shadow_rd + 1'b1;
			r.read_valid = 1'b1;
			r.read_line_end = (r.read_char == KEY_RETURN);
		end
		r.fill_level = shadow_wr - shadow_rd;
		return r;
	endfunction

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			error_count++;
		end
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (tty_results_due.size() == 0) begin
			$error("result word with nothing outstanding: %h", got);
			error_count++;
		end else begin
			want = tty_results_due.pop_front();
			compare_field("echo_valid", 8'(want.echo_valid), 8'(got.echo_valid));
			compare_field("echo_char", want.echo_char, got.echo_char);
			compare_field("key_stored", 8'(want.key_stored), 8'(got.key_stored));
			compare_field("key_dropped", 8'(want.key_dropped), 8'(got.key_dropped));
			compare_field("line_complete", 8'(want.line_complete),
				8'(got.line_complete));
			compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
			compare_field("read_char", want.read_char, got.read_char);
			compare_field("read_line_end", 8'(want.read_line_end),
				8'(got.read_line_end));
			compare_field("fill_level", 8'(want.fill_level), 8'(got.fill_level));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				tty_results_due.push_back(edit_line_buffer(item));
			if (result_valid && !result_stall)
				check_result(result);
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (!rx_steady)
			stall_left = idle_cycles();
		result_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[tty_line_edit_fifo] ERROR");
			$finish;
		end
	end

	task automatic send_word(logic op, logic [7:0] ch);
		item_t w;
		int unsigned gap;
		gap = tx_steady ? 0 : idle_cycles();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.operation = op;
		w.key_char = ch;
		item <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (tty_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_keys_and_reads();
		send_word(OP_READ, 8'hFF);
		send_word(OP_KEY, 8'h00);
		send_word(OP_KEY, 8'hFF);
		send_word(OP_KEY, KEY_RETURN);
		repeat (3) send_word(OP_READ, 8'($urandom));
		send_word(OP_READ, 8'h00);
	endtask

	task automatic test_backspace();
		send_word(OP_KEY, KEY_BACKSPACE);
		send_word(OP_KEY, 8'h61);
		send_word(OP_KEY, KEY_BACKSPACE);
		send_word(OP_KEY, KEY_RETURN);
		send_word(OP_KEY, KEY_BACKSPACE);
	endtask

	// The ring enters holding one carriage return and is taken to full twice.
	task automatic test_full_ring();
		repeat (DEPTH - 1) send_word(OP_KEY, 8'($urandom_range(8'h20, 8'h7E)));
		send_word(OP_KEY, 8'h41);
		send_word(OP_KEY, KEY_BACKSPACE);
		send_word(OP_KEY, KEY_RETURN);
		send_word(OP_KEY, 8'h80);
		send_word(OP_KEY, KEY_BACKSPACE);
	endtask

	// Typing-heavy, reading-heavy and mixed phases are picked at random so the ring swings between empty and full.
	task automatic test_random_editing(int unsigned n_words);
		int unsigned sent;
		int unsigned phase_left;
		int unsigned key_pct;
		int unsigned r;
		logic [7:0] ch;
		sent = 0;
		phase_left = 0;
		key_pct = 50;
		while (sent < n_words) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(8, 40);
				r = $urandom_range(0, 2);
				key_pct = (r == 0) ? 85 : ((r == 1) ? 20 : 50);
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < key_pct) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					ch = KEY_BACKSPACE;
				else if (r < 27)
					ch = KEY_RETURN;
				else
					ch = 8'($urandom);
				send_word(OP_KEY, ch);
			end else begin
				send_word(OP_READ, 8'($urandom));
			end
			phase_left--;
			sent++;
			if (sent == n_words / 2)
				drain_results();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			shadow_ring[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keys_and_reads();
		test_backspace();
		test_full_ring();
		test_random_editing(RANDOM_WORDS);
		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("[tty_line_edit_fifo] OK");
		else
			$display("[tty_line_edit_fifo] ERROR");
		$finish;
	end

endmodule
